// ===== src/temp_alarm_panel_controller_defines.svh =====
// Assertion macros used by the temperature alarm panel checker.
`ifndef TEMP_ALARM_PANEL_CONTROLLER_DEFINES_SVH
`define TEMP_ALARM_PANEL_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked only outside the given disable condition.
`define TAPC_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("temp alarm panel: same-cycle check failed");

// Next-cycle implication, checked only outside the given disable condition.
`define TAPC_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("temp alarm panel: next-cycle check failed");

`endif

// ===== src/tapc_pkg.sv =====
// Package with the word types, register map and constants of the alarm panel.
`default_nettype none

package tapc_pkg;

    // Width of the internal millisecond time base.
    localparam int TIME_BITS = 32;
    localparam int NOW_BITS  = 32;

    typedef logic [TIME_BITS-1:0] t_time;

    // Configuration register map.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS    = 3'd0,
        CFG_BLINK_HALF_MS  = 3'd1,
        CFG_THRESHOLD_MIN  = 3'd2,
        CFG_THRESHOLD_MAX  = 3'd3,
        CFG_THRESHOLD_STEP = 3'd4
    } t_cfg_idx;

    // Input word opcodes.
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_BUTTON  = 2'd1,
        OP_REFRESH = 2'd2
    } t_opcode;

    // Button identifiers.
    localparam logic BTN_INC = 1'b0;

    // Active-low segment patterns, bit0 is segment A.
    localparam logic [6:0] SEG_BLANK = 7'h7F;
    localparam logic [6:0] SEG_F     = 7'h0E;
    localparam logic [6:0] SEG_D     = 7'h21;
    localparam logic [6:0] SEG_7     = 7'h78;
    localparam logic [6:0] SEG_3     = 7'h30;
    localparam logic [6:0] SEG_0     = 7'h40;

    // Upper bounds of threshold minus temperature for each digit.
    localparam logic signed [9:0] DIFF_D_MAX = 10'sd2;
    localparam logic signed [9:0] DIFF_7_MAX = 10'sd10;
    localparam logic signed [9:0] DIFF_3_MAX = 10'sd15;
    localparam logic signed [9:0] DIFF_0_MAX = 10'sd20;

    // Threshold saturation ceiling.
    localparam logic [6:0] THR_CEIL = 7'd127;

    // Reset values of the panel state.
    localparam logic [6:0]        THR_RESET  = 7'd25;
    localparam logic signed [7:0] TEMP_RESET = 8'sd20;

    // Reset values of the configuration registers.
    localparam logic [9:0]  DEBOUNCE_RESET   = 10'd50;
    localparam logic [13:0] BLINK_RESET      = 14'd500;
    localparam logic [6:0]  THR_MIN_RESET    = 7'd10;
    localparam logic [6:0]  THR_MAX_RESET    = 7'd50;
    localparam logic [4:0]  THR_STEP_RESET   = 5'd5;

    typedef struct packed {
        logic [1:0]          opcode;
        logic signed [7:0]   temp_c;
        logic                button_id;
        logic                button_level;
        logic [NOW_BITS-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [6:0]        segments_n;
        logic              alarm_on;
        logic [6:0]        alarm_threshold;
        logic signed [7:0] current_temp;
    } t_out_word;

    typedef struct packed {
        logic [9:0]  debounce_ms;
        logic [13:0] blink_half_ms;
        logic [6:0]  threshold_min;
        logic [6:0]  threshold_max;
        logic [4:0]  threshold_step;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/temp_alarm_panel_controller.sv =====
// Top level of the temperature alarm panel: input register, core and result register.
// Words pass from the input register through the core to the result register.
// Throughput: one word per cycle unless the result side stalls; every input word
// gives exactly one result word. The rate is set by the combinational core logic.
// Reset is synchronous and active low; it clears both valid flags and the panel state.
// Configuration writes are always ready and take effect on the next cycle.
`default_nettype none

module temp_alarm_panel_controller
    import tapc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_word              i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_word                  o_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_in_word  r_in;
    logic      r_in_vld;
    t_out_word r_out;
    logic      r_out_vld;
    t_out_word result;
    logic      adv;
    logic      accept;

    assign o_cfg_ready = 1'b1;

    tapc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // A word moves on when the result register is empty or being taken.
    assign adv     = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !adv;
    assign accept  = i_valid && !o_stall;

    tapc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== src/tapc_cfg_regs.sv =====
// Configuration register file of the alarm panel.
`default_nettype none

module tapc_cfg_regs
    import tapc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes past the map are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= DEBOUNCE_RESET;
            r_cfg.blink_half_ms  <= BLINK_RESET;
            r_cfg.threshold_min  <= THR_MIN_RESET;
            r_cfg.threshold_max  <= THR_MAX_RESET;
            r_cfg.threshold_step <= THR_STEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:    r_cfg.debounce_ms    <= i_cfg_data[9:0];
                CFG_BLINK_HALF_MS:  r_cfg.blink_half_ms  <= i_cfg_data[13:0];
                CFG_THRESHOLD_MIN:  r_cfg.threshold_min  <= i_cfg_data[6:0];
                CFG_THRESHOLD_MAX:  r_cfg.threshold_max  <= i_cfg_data[6:0];
                CFG_THRESHOLD_STEP: r_cfg.threshold_step <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/tapc_core.sv =====
// Panel state and the single-pass update logic for one input word.
`default_nettype none

module tapc_core
    import tapc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire t_in_word i_item,
    input  wire t_cfg     i_cfg,
    output t_out_word     o_result
);

    logic [6:0]        r_thr;
    logic signed [7:0] r_temp;
    logic              r_alarm;
    logic              r_lvl [2];
    t_time             r_press [2];
    logic              r_vis;
    t_time             r_blink_t;
    logic [6:0]        r_seg;

    logic [6:0]        n_thr;
    logic signed [7:0] n_temp;
    logic              n_alarm;
    logic              n_lvl;
    t_time             n_press;
    logic              n_vis;
    t_time             n_blink_t;
    logic [6:0]        n_seg;

    t_time             now;
    logic              btn;
    logic [7:0]        thr_sum;
    logic [6:0]        thr_inc;
    logic [6:0]        thr_dec;
    t_time             press_elapsed;
    logic              falling;
    logic              press_ok;
    logic signed [9:0] diff;
    logic [6:0]        pattern;
    t_time             blink_elapsed;
    logic              blink_toggle;

    // Time base, button edge and debounce check.
    always_comb begin
        now           = t_time'(i_item.now_ms);
        btn           = i_item.button_id;
        press_elapsed = now - r_press[btn];
        falling       = !i_item.button_level && r_lvl[btn];
        press_ok      = falling && (press_elapsed >= t_time'(i_cfg.debounce_ms));
    end

    // Saturating threshold moves.
    always_comb begin
        thr_sum = {1'b0, r_thr} + {3'b000, i_cfg.threshold_step};
        thr_inc = (thr_sum > {1'b0, THR_CEIL}) ? THR_CEIL : thr_sum[6:0];
        thr_dec = (r_thr > {2'b00, i_cfg.threshold_step}) ?
                  (r_thr - {2'b00, i_cfg.threshold_step}) : 7'd0;
    end

    // Digit choice from the margin between threshold and temperature.
    always_comb begin
        diff = $signed({3'b000, r_thr}) - $signed({{2{r_temp[7]}}, r_temp});
        if (r_alarm) begin
            pattern = SEG_F;
        end else if (diff <= DIFF_D_MAX) begin
            pattern = SEG_D;
        end else if (diff <= DIFF_7_MAX) begin
            pattern = SEG_7;
        end else if (diff <= DIFF_3_MAX) begin
            pattern = SEG_3;
        end else if (diff <= DIFF_0_MAX) begin
            pattern = SEG_0;
        end else begin
            pattern = SEG_BLANK;
        end
        blink_elapsed = now - r_blink_t;
        blink_toggle  = r_alarm && (blink_elapsed > t_time'(i_cfg.blink_half_ms));
    end

    // Next state for the word in the input register.
    always_comb begin
        n_thr     = r_thr;
        n_temp    = r_temp;
        n_alarm   = r_alarm;
        n_lvl     = r_lvl[btn];
        n_press   = r_press[btn];
        n_vis     = r_vis;
        n_blink_t = r_blink_t;
        n_seg     = r_seg;
        case (i_item.opcode)
            OP_SAMPLE: begin
                n_temp  = i_item.temp_c;
                n_alarm = $signed({i_item.temp_c[7], i_item.temp_c}) >=
                          $signed({2'b00, r_thr});
            end
            OP_BUTTON: begin
                n_lvl = i_item.button_level;
                if (press_ok) begin
                    n_press = now;
                    if (btn == BTN_INC) begin
                        if (r_thr < i_cfg.threshold_max) begin
                            n_thr = thr_inc;
                        end
                    end else begin
                        if (r_thr > i_cfg.threshold_min) begin
                            n_thr = thr_dec;
                        end
                    end
                end
            end
            OP_REFRESH: begin
                if (!r_alarm) begin
                    n_vis = 1'b1;
                end else if (blink_toggle) begin
                    n_vis     = !r_vis;
                    n_blink_t = now;
                end
                n_seg = n_vis ? pattern : SEG_BLANK;
            end
            default: ;
        endcase
    end

    // State registers, updated when the word moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RESET;
            r_temp     <= TEMP_RESET;
            r_alarm    <= 1'b0;
            r_lvl[0]   <= 1'b1;
            r_lvl[1]   <= 1'b1;
            r_press[0] <= '0;
            r_press[1] <= '0;
            r_vis      <= 1'b1;
            r_blink_t  <= '0;
            r_seg      <= SEG_BLANK;
        end else if (i_adv) begin
            r_thr        <= n_thr;
            r_temp       <= n_temp;
            r_alarm      <= n_alarm;
            r_lvl[btn]   <= n_lvl;
            r_press[btn] <= n_press;
            r_vis        <= n_vis;
            r_blink_t    <= n_blink_t;
            r_seg        <= n_seg;
        end
    end

    // Result word reflects the state after this word.
    always_comb begin
        o_result.segments_n      = n_seg;
        o_result.alarm_on        = n_alarm;
        o_result.alarm_threshold = n_thr;
        o_result.current_temp    = n_temp;
    end

endmodule

`default_nettype wire

// ===== src/tapc_checker.sv =====
// Port-level checker for the alarm panel and its bind to the top level.
`default_nettype none
`include "temp_alarm_panel_controller_defines.svh"

module tapc_checker
    import tapc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire t_in_word  i_data,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_word o_data
);

    // After reset neither side holds a word.
    `TAPC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid && !o_stall)

    // The input side stalls only while a result word is held back.
    `TAPC_ASSERT_SAME(a_stall_cause, i_clk, !i_rst_n, o_stall, o_valid && i_stall)

    // A stalled result word stays put.
    `TAPC_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall,
                      o_valid && $stable(o_data))

    // A stalled input word stays put.
    `TAPC_ASSERT_NEXT(a_in_hold, i_clk, !i_rst_n, i_valid && o_stall,
                      i_valid && $stable(i_data))

endmodule

bind temp_alarm_panel_controller tapc_checker u_tapc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

// ===== tb/panel_readout_checker.sv =====
`timescale 1ns / 1ps
// Checker that mirrors the alarm panel state and compares every readout word it returns.
module panel_readout_checker
    import tapc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int REPORT_LIMIT = 10;

    // Mirrored register settings.
    t_cfg              panel_cfg;

    // Mirrored panel state.
    int                thr_deg;
    logic signed [7:0] latched_temp;
    logic              alarm_flag;
    logic              btn_level [2];
    t_time             press_time [2];
    logic              blink_visible;
    t_time             blink_time;
    logic [6:0]        shown_segments;

    // Readout words predicted for accepted input words, oldest first.
    t_out_word         readout_q [$];

    // Applies one input word to the mirrored state and queues the readout it must give.
    task automatic predict_readout(input t_in_word w);
        t_out_word  readout;
        t_time      now;
        t_time      elapsed;
        logic       btn;
        int         raised;
        int         diff;
        logic [6:0] pattern;
        now = t_time'(w.now_ms);
        case (w.opcode)
            OP_SAMPLE: begin
                latched_temp = w.temp_c;
                alarm_flag   = int'(w.temp_c) >= thr_deg;
            end
            OP_BUTTON: begin
                btn = w.button_id;
                // Only a falling level outside the debounce window counts as a press.
                if (!w.button_level && btn_level[btn]) begin
                    elapsed = now - press_time[btn];
                    if (elapsed >= t_time'(panel_cfg.debounce_ms)) begin
                        if (btn == BTN_INC) begin
                            if (thr_deg < int'(panel_cfg.threshold_max)) begin
                                raised  = thr_deg + int'(panel_cfg.threshold_step);
                                thr_deg = (raised > int'(THR_CEIL)) ? int'(THR_CEIL) : raised;
                            end
                        end else if (thr_deg > int'(panel_cfg.threshold_min)) begin
                            thr_deg = (thr_deg > int'(panel_cfg.threshold_step)) ?
                                      thr_deg - int'(panel_cfg.threshold_step) : 0;
                        end
                        press_time[btn] = now;
                    end
                end
                btn_level[btn] = w.button_level;
            end
            OP_REFRESH: begin
                // The digit depends on how far the temperature sits below the threshold.
                diff = thr_deg - int'(latched_temp);
                if (alarm_flag) begin
                    pattern = SEG_F;
                end else if (diff <= DIFF_D_MAX) begin
                    pattern = SEG_D;
                end else if (diff <= DIFF_7_MAX) begin
                    pattern = SEG_7;
                end else if (diff <= DIFF_3_MAX) begin
                    pattern = SEG_3;
                end else if (diff <= DIFF_0_MAX) begin
                    pattern = SEG_0;
                end else begin
                    pattern = SEG_BLANK;
                end
                // Blinking runs only during alarm; otherwise the digit stays visible.
                if (alarm_flag) begin
                    elapsed = now - blink_time;
                    if (elapsed > t_time'(panel_cfg.blink_half_ms)) begin
                        blink_time    = now;
                        blink_visible = ~blink_visible;
                    end
                end else begin
                    blink_visible = 1'b1;
                end
                shown_segments = blink_visible ? pattern : SEG_BLANK;
            end
            default: begin
            end
        endcase
        readout.segments_n      = shown_segments;
        readout.alarm_on        = alarm_flag;
        readout.alarm_threshold = 7'(thr_deg);
        readout.current_temp    = latched_temp;
        readout_q.push_back(readout);
    endtask

    // Watch all three channels at the clock edge.
    always @(posedge i_clk) begin : watch
        t_out_word expected;
        if (!i_rst_n) begin
            panel_cfg.debounce_ms    = DEBOUNCE_RESET;
            panel_cfg.blink_half_ms  = BLINK_RESET;
            panel_cfg.threshold_min  = THR_MIN_RESET;
            panel_cfg.threshold_max  = THR_MAX_RESET;
            panel_cfg.threshold_step = THR_STEP_RESET;
            thr_deg        = int'(THR_RESET);
            latched_temp   = TEMP_RESET;
            alarm_flag     = 1'b0;
            btn_level[0]   = 1'b1;
            btn_level[1]   = 1'b1;
            press_time[0]  = '0;
            press_time[1]  = '0;
            blink_visible  = 1'b1;
            blink_time     = '0;
            shown_segments = SEG_BLANK;
            readout_q.delete();
            o_fail_count   = 0;
            o_checked      = 0;
        end else begin
            // Register writes; unknown indexes leave everything alone.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE_MS:    panel_cfg.debounce_ms    = i_cfg_data[9:0];
                    CFG_BLINK_HALF_MS:  panel_cfg.blink_half_ms  = i_cfg_data[13:0];
                    CFG_THRESHOLD_MIN:  panel_cfg.threshold_min  = i_cfg_data[6:0];
                    CFG_THRESHOLD_MAX:  panel_cfg.threshold_max  = i_cfg_data[6:0];
                    CFG_THRESHOLD_STEP: panel_cfg.threshold_step = i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            // Compare each returned word with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (readout_q.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT) begin
                        $display("ERROR: readout %h arrived with no word outstanding",
                                 i_out_data);
                    end
                    o_fail_count++;
                end else begin
                    expected = readout_q.pop_front();
                    if (i_out_data.segments_n !== expected.segments_n ||
                        i_out_data.alarm_on !== expected.alarm_on ||
                        i_out_data.alarm_threshold !== expected.alarm_threshold ||
                        i_out_data.current_temp !== expected.current_temp) begin
                        if (o_fail_count < REPORT_LIMIT) begin
                            $display({"ERROR: readout %0d expected seg=%h alarm=%b thr=%0d ",
                                      "temp=%0d, got seg=%h alarm=%b thr=%0d temp=%0d"},
                                     o_checked, expected.segments_n, expected.alarm_on,
                                     expected.alarm_threshold, expected.current_temp,
                                     i_out_data.segments_n, i_out_data.alarm_on,
                                     i_out_data.alarm_threshold, i_out_data.current_temp);
                        end
                        o_fail_count++;
                    end
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_readout(i_in_data);
            end
        end
        o_pending = readout_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the alarm panel testbench: clock, reset, stimulus, stalls and the verdict.
module tb_top;
    import tapc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_WORDS = 300;

    localparam logic [1:0]            OP_UNUSED     = 2'd3;
    localparam logic                  BTN_DEC       = ~BTN_INC;
    localparam logic                  LVL_PRESSED   = 1'b0;
    localparam logic                  LVL_RELEASED  = 1'b1;
    localparam logic [CFG_IDX_W-1:0]  CFG_IDX_SPARE = 3'd7;
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES  = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_word              i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out_word             o_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bit    idle_on = 1'b1;
    t_time now_cursor;
    logic  sent_level [2];
    int    cur_debounce;
    int    cur_blink;
    int    words_sent;
    int    settings_used;
    int    fail_count;
    int    pending;
    int    checked;
    int    quiet;

    temp_alarm_panel_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    panel_readout_checker readout_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: random stall bursts while idling is enabled.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: the run ends if no word moves on any channel for too long.
    initial begin
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Presents one word, possibly after an idle gap, and holds it until accepted.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input t_in_word w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_fields(input logic [1:0] op, input int temp, input logic btn,
                               input logic level, input t_time now);
        t_in_word w;
        w.opcode       = op;
        w.temp_c       = 8'(temp);
        w.button_id    = btn;
        w.button_level = level;
        w.now_ms       = now;
        send_word(w);
    endtask

    // Lets every outstanding readout come back before anything else happens.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_panel(input int debounce, input int blink, input int tmin,
                                 input int tmax, input int tstep);
        write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'(debounce));
        write_reg(CFG_BLINK_HALF_MS, CFG_DATA_W'(blink));
        write_reg(CFG_THRESHOLD_MIN, CFG_DATA_W'(tmin));
        write_reg(CFG_THRESHOLD_MAX, CFG_DATA_W'(tmax));
        write_reg(CFG_THRESHOLD_STEP, CFG_DATA_W'(tstep));
        cur_debounce = int'(debounce[9:0]);
        cur_blink    = int'(blink[13:0]);
        settings_used++;
    endtask

    // Mostly well-formed traffic: press/release pairs and refreshes on a moving clock,
    // temperatures near the threshold band, plus some noise.
    task automatic send_random_word();
        t_in_word w;
        int       pick;
        w.opcode       = OP_UNUSED;
        w.temp_c       = 8'($urandom);
        w.button_id    = 1'($urandom);
        w.button_level = 1'($urandom);
        w.now_ms       = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            w.opcode = OP_SAMPLE;
            if ($urandom_range(0, 4) != 0) begin
                w.temp_c = 8'(int'($urandom_range(0, 115)) - 5);
            end
        end else if (pick < 66) begin
            w.opcode = OP_BUTTON;
            if ($urandom_range(0, 4) != 0) begin
                w.button_level = ~sent_level[w.button_id];
            end
            sent_level[w.button_id] = w.button_level;
            now_cursor += $urandom_range(0, 2 * cur_debounce + 20);
            if ($urandom_range(0, 15) != 0) begin
                w.now_ms = now_cursor;
            end
        end else if (pick < 96) begin
            w.opcode = OP_REFRESH;
            now_cursor += $urandom_range(0, cur_blink + cur_blink / 2 + 20);
            if ($urandom_range(0, 15) != 0) begin
                w.now_ms = now_cursor;
            end
        end
        send_word(w);
    endtask

    // Main stimulus sequence.
    initial begin
        int tmin;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        sent_level[0] = LVL_RELEASED;
        sent_level[1] = LVL_RELEASED;
        cur_debounce  = int'(DEBOUNCE_RESET);
        cur_blink     = int'(BLINK_RESET);
        words_sent    = 0;
        settings_used = 1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Display after reset, then an unused opcode with every field bit set but the button level.
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_PRESSED, 32'd0);
        send_fields(OP_UNUSED, -1, BTN_DEC, LVL_PRESSED, 32'hFFFF_FFFF);
        // Alarm exactly at the threshold, then blinking around the half period.
        send_fields(OP_SAMPLE, 25, BTN_INC, LVL_RELEASED, 32'd0);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd100);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd601);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd1101);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd1102);
        // A raised threshold must not clear the alarm; a quick second press is bounced.
        send_fields(OP_BUTTON, 0, BTN_INC, LVL_RELEASED, 32'd1110);
        send_fields(OP_BUTTON, 0, BTN_INC, LVL_PRESSED, 32'd1120);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd1200);
        send_fields(OP_BUTTON, 0, BTN_INC, LVL_RELEASED, 32'd1130);
        send_fields(OP_BUTTON, 0, BTN_INC, LVL_PRESSED, 32'd1140);
        // Temperature extremes and the digit bands.
        send_fields(OP_SAMPLE, 127, BTN_INC, LVL_RELEASED, 32'd0);
        send_fields(OP_SAMPLE, -128, BTN_INC, LVL_RELEASED, 32'd0);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd1300);
        send_fields(OP_SAMPLE, 12, BTN_INC, LVL_RELEASED, 32'd0);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd1310);
        send_fields(OP_SAMPLE, 17, BTN_INC, LVL_RELEASED, 32'd0);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd1320);
        // Decrements, the last one across the wrap of the millisecond counter.
        send_fields(OP_BUTTON, 0, BTN_DEC, LVL_PRESSED, 32'd1400);
        send_fields(OP_BUTTON, 0, BTN_DEC, LVL_RELEASED, 32'hFFFF_FFE0);
        send_fields(OP_BUTTON, 0, BTN_DEC, LVL_PRESSED, 32'hFFFF_FFF0);
        send_fields(OP_BUTTON, 0, BTN_DEC, LVL_RELEASED, 32'h0000_0010);
        send_fields(OP_BUTTON, 0, BTN_DEC, LVL_PRESSED, 32'h0000_0030);

        // Odd limits: no debounce, no blink delay, wide step to hit both saturations.
        drain();
        program_panel(0, 0, 0, 127, 31);
        write_reg(CFG_IDX_SPARE, CFG_ALL_ONES);
        repeat (5) begin
            send_fields(OP_BUTTON, 0, BTN_INC, LVL_RELEASED, 32'd5000);
            send_fields(OP_BUTTON, 0, BTN_INC, LVL_PRESSED, 32'd5000);
        end
        repeat (6) begin
            send_fields(OP_BUTTON, 0, BTN_DEC, LVL_RELEASED, 32'd5000);
            send_fields(OP_BUTTON, 0, BTN_DEC, LVL_PRESSED, 32'd5000);
        end
        send_fields(OP_SAMPLE, 0, BTN_INC, LVL_RELEASED, 32'd0);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd5000);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd5000);
        send_fields(OP_REFRESH, 0, BTN_INC, LVL_RELEASED, 32'd5001);
        sent_level[0] = LVL_PRESSED;
        sent_level[1] = LVL_PRESSED;

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0: program_panel(1, 1, 0, 100, 20);
                1: program_panel(1000, 10000, 100, 100, 1);
                4: program_panel($urandom_range(0, 1023), $urandom_range(0, 16383),
                                 $urandom_range(0, 127), $urandom_range(0, 127), 0);
                5: program_panel(int'(CFG_ALL_ONES), int'(CFG_ALL_ONES), int'(CFG_ALL_ONES),
                                 int'(CFG_ALL_ONES), int'(CFG_ALL_ONES));
                default: begin
                    tmin = $urandom_range(0, 60);
                    program_panel($urandom_range(1, 1000), $urandom_range(1, 10000), tmin,
                                  $urandom_range(tmin, 100), $urandom_range(1, 20));
                end
            endcase
            idle_on = (p != NUM_PHASES - 1);
            if ($urandom_range(0, 1) == 0) begin
                now_cursor = $urandom;
            end else begin
                now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 30000);
            end
            repeat (PHASE_WORDS) begin
                if ($urandom_range(0, 149) == 0) begin
                    drain();
                end
                send_random_word();
            end
        end

        // Wind down and give the verdict.
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (pending != 0) begin
            $display("ERROR: %0d readouts never arrived", pending);
        end
        $display("Covered %0d input words and %0d readouts over %0d register settings.",
                 words_sent, checked, settings_used);
        $display("Included bounced presses, threshold saturation, blinking and time wrap.");
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/tapc_pkg.sv
src/tapc_cfg_regs.sv
src/tapc_core.sv
src/temp_alarm_panel_controller.sv
src/tapc_checker.sv
tb/panel_readout_checker.sv
tb/tb_top.sv
